[rtl/psr_pkg.sv]
// Shared constants, register codes and types of the PWM hysteresis step regulator.
package psr_pkg;

	localparam int WINDOW     = 8;
	localparam int DUTY_RES   = 16;
	localparam int DUTY_HALF  = DUTY_RES / 2;

	localparam int SAMPLE_W   = 10;
	localparam int TARGET_W   = 13;
	localparam int HYST_W     = 10;
	localparam int STEP_W     = 12;
	localparam int DUTY_W     = 12;
	localparam int CMP_W      = 8;
	localparam int AVG_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int SUM_MAX    = WINDOW * SAMPLE_MAX;
	localparam int SUM_W      = $clog2(SUM_MAX + 1);
	localparam int MARGIN_MAX = WINDOW * ((1 << HYST_W) - 1);
	localparam int MARGIN_W   = $clog2(MARGIN_MAX + 1);
	localparam int WIDE_SM    = (SUM_W > MARGIN_W) ? SUM_W : MARGIN_W;
	localparam int BAND_W     = ((WIDE_SM > TARGET_W) ? WIDE_SM : TARGET_W) + 1;

	localparam int RING_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PHASE_W    = (DUTY_RES > 1) ? $clog2(DUTY_RES) : 1;

	localparam int AVG_MAX    = (1 << AVG_W) - 1;
	localparam int CMP_MAX    = (1 << CMP_W) - 1;

	localparam int TARGET_RST_RAW = 512 * WINDOW;
	localparam int TARGET_RST     = (TARGET_RST_RAW > AVG_MAX) ? AVG_MAX : TARGET_RST_RAW;
	localparam int HYST_RST       = 4;
	localparam int STEP_RST       = 1;
	localparam int UPPER_RST      = 3840;
	localparam int LOWER_RST      = 0;
	localparam int DITHER_RST     = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_SUM    = 3'd0,
		CFG_HYSTERESIS    = 3'd1,
		CFG_STEP_SIZE     = 3'd2,
		CFG_DUTY_UPPER    = 3'd3,
		CFG_DUTY_LOWER    = 3'd4,
		CFG_DITHER_ENABLE = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [TARGET_W-1:0] target_sum;
		logic [HYST_W-1:0]   hysteresis;
		logic [STEP_W-1:0]   step_size;
		logic [DUTY_W-1:0]   duty_upper;
		logic [DUTY_W-1:0]   duty_lower;
		logic                dither_enable;
	} cfg_t;

endpackage

[rtl/psr_avg.sv]
// Sample ring and running sum of the last WINDOW converter samples.
module psr_avg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [psr_pkg::SAMPLE_W-1:0] sample,
	output logic [psr_pkg::SUM_W-1:0]    sum
);
	import psr_pkg::*;

	logic [SAMPLE_W-1:0]   ring_q [WINDOW];
	logic [RING_IDX_W-1:0] idx_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      sum_nxt;

	// The true result always lies in range, so modular arithmetic is exact.
	assign sum_nxt = sum_q + SUM_W'(sample) - SUM_W'(ring_q[idx_q]);
	assign sum     = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			idx_q <= '0;
			sum_q <= '0;
		end else if (load) begin
			ring_q[idx_q] <= sample;
			sum_q         <= sum_nxt;
			if (idx_q == RING_IDX_W'(WINDOW - 1)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

[rtl/psr_duty.sv]
// Hysteresis duty stepper, dither phase and PWM compare value generation.
module psr_duty (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step_en,
	input  logic [psr_pkg::SUM_W-1:0]  sum,
	input  psr_pkg::cfg_t              cfg,
	output logic [psr_pkg::DUTY_W-1:0] duty_nxt,
	output logic [psr_pkg::CMP_W-1:0]  compare_nxt
);
	import psr_pkg::*;

	logic [DUTY_W-1:0]  duty_q;
	logic [PHASE_W-1:0] phase_q;

	logic [BAND_W-1:0]  sum_w;
	logic [BAND_W-1:0]  tgt_w;
	logic [BAND_W-1:0]  margin_w;
	logic               below;
	logic               above;
	logic [DUTY_W:0]    step_w;
	logic [DUTY_W:0]    up_sum;
	logic [DUTY_W:0]    dn_limit;
	logic               can_up;
	logic               can_dn;
	logic [DUTY_W:0]    whole;
	logic [PHASE_W-1:0] frac;
	logic [DUTY_W:0]    cmp_raw;

	always_comb begin
		sum_w    = BAND_W'(sum);
		tgt_w    = BAND_W'(cfg.target_sum);
		margin_w = BAND_W'(cfg.hysteresis) * BAND_W'(WINDOW);
		below    = (sum_w + margin_w) < tgt_w;
		above    = sum_w > (tgt_w + margin_w);

		// Limit tests are made one bit wider so that neither side wraps.
		step_w   = (DUTY_W+1)'(cfg.step_size);
		up_sum   = (DUTY_W+1)'(duty_q) + step_w;
		dn_limit = (DUTY_W+1)'(cfg.duty_lower) + step_w;
		can_up   = up_sum <= (DUTY_W+1)'(cfg.duty_upper);
		can_dn   = (DUTY_W+1)'(duty_q) >= dn_limit;

		if (below && can_up) begin
			duty_nxt = up_sum[DUTY_W-1:0];
		end else if (above && can_dn) begin
			duty_nxt = duty_q - DUTY_W'(cfg.step_size);
		end else begin
			duty_nxt = duty_q;
		end

		whole = (DUTY_W+1)'(duty_nxt / DUTY_RES);
		frac  = PHASE_W'(duty_nxt % DUTY_RES);
		if (cfg.dither_enable) begin
			cmp_raw = whole + (DUTY_W+1)'(frac < phase_q);
		end else begin
			cmp_raw = (DUTY_W+1)'(((DUTY_W+1)'(duty_nxt) + (DUTY_W+1)'(DUTY_HALF)) / DUTY_RES);
		end
		compare_nxt = (cmp_raw > (DUTY_W+1)'(CMP_MAX)) ? CMP_W'(CMP_MAX) : cmp_raw[CMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q  <= '0;
			phase_q <= '0;
		end else if (step_en) begin
			duty_q <= duty_nxt;
			if (phase_q == PHASE_W'(DUTY_RES - 1)) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + 1'b1;
			end
		end
	end

endmodule

[rtl/pwm_hysteresis_step_regulator_top.sv]
// Top level of the moving-average hysteresis PWM step regulator.
// Each accepted converter sample enters a ring of the last eight samples and
// updates their running sum in the cycle it is accepted. In the input stage the
// sum is compared against the target with a dead band of eight times the
// hysteresis register, the fine duty value steps up or down by step_size where
// the duty limits allow it, and the 8-bit compare value is formed, either
// rounded to the nearest count or dithered against a free-running 16-step
// phase that advances once per request. The result is loaded into an output
// register when the input stage advances, which it does once the output
// register is empty or its result is being taken. One request can be accepted
// on every cycle while the consumer keeps taking results: the input stage and
// the output register form a two-entry pipeline; the feedback loops are the
// running-sum update and ring index, the duty update and the phase counter.
// Configuration is always ready (cfg_ready is tied high); indexes 0 to 5
// select target_sum, hysteresis, step_size, duty_upper, duty_lower and
// dither_enable, and writes to other indexes are dropped.
// Registers should only be written while no request is in flight. Reset clears
// the sample ring, sum, duty value and phase and loads the register defaults.
module pwm_hysteresis_step_regulator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [psr_pkg::SAMPLE_W-1:0]   adc_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [psr_pkg::CMP_W-1:0]      compare_value,
	output logic [psr_pkg::DUTY_W-1:0]     duty_fine,
	output logic [psr_pkg::AVG_W-1:0]      average_sum,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import psr_pkg::*;

	cfg_t              cfg_q;
	logic              s1_valid_q;
	logic              out_valid_q;
	logic [CMP_W-1:0]  compare_value_q;
	logic [DUTY_W-1:0] duty_fine_q;
	logic [AVG_W-1:0]  average_sum_q;

	logic              out_free;
	logic              s1_adv;
	logic              in_accept;
	logic [SUM_W-1:0]  sum;
	logic [31:0]       sum_wide;
	logic [AVG_W-1:0]  avg_sat;
	logic [DUTY_W-1:0] duty_nxt;
	logic [CMP_W-1:0]  compare_nxt;

	// The output register frees up in the same cycle its result is taken, so
	// a full pipeline keeps moving as long as the consumer keeps taking.
	assign out_free  = !out_valid_q || out_ready;
	assign s1_adv    = s1_valid_q && out_free;
	assign in_ready  = !s1_valid_q || out_free;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign out_valid     = out_valid_q;
	assign compare_value = compare_value_q;
	assign duty_fine     = duty_fine_q;
	assign average_sum   = average_sum_q;

	// The running sum register doubles as the first stage's data: it only
	// changes on acceptance, which cannot happen while stage one is stalled.
	psr_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_accept),
		.sample (adc_sample),
		.sum    (sum)
	);

	psr_duty u_duty (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (s1_adv),
		.sum         (sum),
		.cfg         (cfg_q),
		.duty_nxt    (duty_nxt),
		.compare_nxt (compare_nxt)
	);

	// The reported sum saturates at the output width; inside it is kept whole.
	assign sum_wide = 32'(sum);
	assign avg_sat  = (sum_wide > 32'(AVG_MAX)) ? AVG_W'(AVG_MAX) : sum_wide[AVG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_sum    <= TARGET_W'(TARGET_RST);
			cfg_q.hysteresis    <= HYST_W'(HYST_RST);
			cfg_q.step_size     <= STEP_W'(STEP_RST);
			cfg_q.duty_upper    <= DUTY_W'(UPPER_RST);
			cfg_q.duty_lower    <= DUTY_W'(LOWER_RST);
			cfg_q.dither_enable <= 1'(DITHER_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TARGET_SUM:    cfg_q.target_sum    <= cfg_data[TARGET_W-1:0];
				CFG_HYSTERESIS:    cfg_q.hysteresis    <= cfg_data[HYST_W-1:0];
				CFG_STEP_SIZE:     cfg_q.step_size     <= cfg_data[STEP_W-1:0];
				CFG_DUTY_UPPER:    cfg_q.duty_upper    <= cfg_data[DUTY_W-1:0];
				CFG_DUTY_LOWER:    cfg_q.duty_lower    <= cfg_data[DUTY_W-1:0];
				CFG_DITHER_ENABLE: cfg_q.dither_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			compare_value_q <= compare_nxt;
			duty_fine_q     <= duty_nxt;
			average_sum_q   <= avg_sat;
		end
	end

endmodule

[rtl/psr_checker.sv]
// Port-level checks of the regulator, bound to its top level.
module psr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [psr_pkg::SAMPLE_W-1:0]   adc_sample,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [psr_pkg::CMP_W-1:0]      compare_value,
	input logic [psr_pkg::DUTY_W-1:0]     duty_fine,
	input logic [psr_pkg::AVG_W-1:0]      average_sum,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [psr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import psr_pkg::*;

	logic [2:0]      pending_q;
	logic            dither_q;
	logic [DUTY_W:0] round_raw;
	logic [CMP_W-1:0] round_cmp;
	logic            in_acc;
	logic            out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Requests accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			dither_q  <= 1'(DITHER_RST);
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
			if (cfg_valid && cfg_ready && cfg_index == CFG_DITHER_ENABLE) begin
				dither_q <= cfg_data[0];
			end
		end
	end

	assign round_raw = (DUTY_W+1)'(((DUTY_W+1)'(duty_fine) + (DUTY_W+1)'(DUTY_HALF)) / DUTY_RES);
	assign round_cmp = (round_raw > (DUTY_W+1)'(CMP_MAX)) ? CMP_W'(CMP_MAX)
		: round_raw[CMP_W-1:0];

	a_no_phantom_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result shown with no request outstanding");

	a_two_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more than two requests in flight");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(average_sum) <= 32'(SUM_MAX))
		else $error("average sum beyond the largest window sum");

	a_round_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dither_q |-> compare_value == round_cmp)
		else $error("rounded compare value does not match the fine duty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(compare_value)
			&& $stable(duty_fine) && $stable(average_sum))
		else $error("stalled result changed or was withdrawn");

endmodule

bind pwm_hysteresis_step_regulator_top psr_checker u_psr_checker (.*);

[verif/pwm_hysteresis_step_regulator_top_test.sv]
// Self-checking testbench for the PWM hysteresis step regulator top level.
module pwm_hysteresis_step_regulator_top_test;

	import psr_pkg::*;

	// Run length and pacing. Each result passes through the input stage and the
	// output register, so a short drain after the last result is enough to expose
	// any stray output.
	localparam int RANDOM_ITEMS = 1650;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DUTY_TOP     = (1 << DUTY_W) - 1;

	// Register indexes that the block does not map; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic [CMP_W-1:0]  compare;
		logic [DUTY_W-1:0] duty;
		logic [AVG_W-1:0]  average;
	} pwm_result_t;

	// A result typed into the table, used instead of the predictor's own.
	typedef struct packed {
		logic        on;
		pwm_result_t res;
	} pin_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  value;
		logic                   pinned;
		pwm_result_t            want;
	} plan_row_t;

	localparam int DIRECTED_ROWS = 39;

	// Directed walk. It starts from the reset settings, fills the ring with
	// full-scale samples so that the duty climbs, sits in the dead band and then
	// falls to its lower limit, and then moves through the register extremes:
	// a full-range step that saturates the compare value, a target of zero, a
	// step that masks to zero, writes to unmapped indexes, limits that leave
	// the duty outside them, limits that cross, and the widest dead band.
	localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, '0, 13'd0,    1'b1, '{8'd0,   12'd1,    13'd0}},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b1, '{8'd0,   12'd2,    13'd1023}},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_REG, CFG_TARGET_SUM,    13'h1FFF, 1'b0, '0},
		'{ROW_REG, CFG_HYSTERESIS,    13'h0400, 1'b0, '0},
		'{ROW_REG, CFG_STEP_SIZE,     13'h0FFF, 1'b0, '0},
		'{ROW_REG, CFG_DUTY_UPPER,    13'h0FFF, 1'b0, '0},
		'{ROW_REG, CFG_DITHER_ENABLE, 13'h1FFE, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b1, '{8'd255, 12'd4095, 13'd8184}},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_REG, CFG_TARGET_SUM,    13'h0000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd0,    1'b1, '{8'd0,   12'd0,    13'd7161}},
		'{ROW_REG, CFG_STEP_SIZE,     13'h1000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd512,  1'b0, '0},
		'{ROW_REG, CFG_UNMAPPED_LO,   13'h1FFF, 1'b0, '0},
		'{ROW_REG, CFG_UNMAPPED_HI,   13'h0AAA, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_REG, CFG_STEP_SIZE,     13'd1,    1'b0, '0},
		'{ROW_REG, CFG_DUTY_LOWER,    13'd2000, 1'b0, '0},
		'{ROW_REG, CFG_DUTY_UPPER,    13'd3000, 1'b0, '0},
		'{ROW_REG, CFG_TARGET_SUM,    13'h1FFF, 1'b0, '0},
		'{ROW_REG, CFG_DITHER_ENABLE, 13'd1,    1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd0,    1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_REG, CFG_TARGET_SUM,    13'h0000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0},
		'{ROW_REG, CFG_DUTY_LOWER,    13'h0AAA, 1'b0, '0},
		'{ROW_REG, CFG_DUTY_UPPER,    13'h0555, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd341,  1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd682,  1'b0, '0},
		'{ROW_REG, CFG_HYSTERESIS,    13'h03FF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 13'd1023, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   adc_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [CMP_W-1:0]      compare_value;
	logic [DUTY_W-1:0]     duty_fine;
	logic [AVG_W-1:0]      average_sum;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Travels with the sample request, so it lines up with the accepting edge.
	pin_t pinned;

	// Our own copy of the regulator: ring, full-width sum, duty, phase, registers.
	logic [SAMPLE_W-1:0] ring_q [WINDOW];
	logic [SUM_W-1:0]    sum_q;
	int unsigned         slot_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [PHASE_W-1:0]  phase_q;
	cfg_t                regs_q;

	pwm_result_t due_pwm [$];
	pwm_result_t got_pwm;
	pwm_result_t want_pwm;

	int samples_sent;
	int results_seen;
	int reg_writes;
	int settings_used;
	int mismatches;
	int cycles;
	int burst_left;
	bit hold_done;

	pwm_hysteresis_step_regulator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.adc_sample    (adc_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.compare_value (compare_value),
		.duty_fine     (duty_fine),
		.average_sum   (average_sum),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	// Register write as the block sees it: unmapped indexes are dropped and the
	// data is cut to the width of the register.
	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_TARGET_SUM:    regs_q.target_sum    = data[TARGET_W-1:0];
			CFG_HYSTERESIS:    regs_q.hysteresis    = data[HYST_W-1:0];
			CFG_STEP_SIZE:     regs_q.step_size     = data[STEP_W-1:0];
			CFG_DUTY_UPPER:    regs_q.duty_upper    = data[DUTY_W-1:0];
			CFG_DUTY_LOWER:    regs_q.duty_lower    = data[DUTY_W-1:0];
			CFG_DITHER_ENABLE: regs_q.dither_enable = data[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// One sample through the regulator. The band and limit tests are done in
	// signed int, so upper - step and lower + step may fall outside the duty
	// range without wrapping; the duty only moves up when it stays at or below the
	// upper limit, and only moves down when it stays at or above the lower limit.
	function automatic pwm_result_t advance_regulator(input logic [SAMPLE_W-1:0] sample);
		int          level;
		int          target;
		int          margin;
		int          duty;
		int          stride;
		int          whole;
		pwm_result_t r;
		sum_q = sum_q + sample - ring_q[slot_q];
		ring_q[slot_q] = sample;
		level  = int'(sum_q);
		target = int'(regs_q.target_sum);
		margin = int'(regs_q.hysteresis) * WINDOW;
		duty   = int'(duty_q);
		stride = int'(regs_q.step_size);
		if (level < target - margin && duty <= int'(regs_q.duty_upper) - stride) begin
			duty = duty + stride;
		end else if (level > target + margin && duty >= int'(regs_q.duty_lower) + stride) begin
			duty = duty - stride;
		end
		duty_q = duty[DUTY_W-1:0];
		if (regs_q.dither_enable) begin
			// Whole part, plus one while the fraction is below the phase.
			whole = int'(duty_q) / DUTY_RES;
			if (int'(duty_q) % DUTY_RES < int'(phase_q)) begin
				whole = whole + 1;
			end
		end else begin
			whole = (int'(duty_q) + DUTY_HALF) / DUTY_RES;
		end
		r.compare = (whole > CMP_MAX) ? CMP_W'(CMP_MAX) : CMP_W'(whole);
		r.duty    = duty_q;
		r.average = (int'(sum_q) > AVG_MAX) ? AVG_W'(AVG_MAX) : AVG_W'(sum_q);
		slot_q  = (slot_q + 1) % WINDOW;
		phase_q = PHASE_W'((int'(phase_q) + 1) % DUTY_RES);
		return r;
	endfunction

	// Watches all three channels at each rising edge. Results are retired
	// before new requests are recorded; a result can never belong to a request
	// accepted at the same edge, since every request is registered before its result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_pwm.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing outstanding",
						results_seen));
				end else begin
					want_pwm = due_pwm.pop_front();
					if (compare_value !== want_pwm.compare) begin
						report_mismatch($sformatf("result %0d compare_value %0d, expected %0d",
							results_seen, compare_value, want_pwm.compare));
					end
					if (duty_fine !== want_pwm.duty) begin
						report_mismatch($sformatf("result %0d duty_fine %0d, expected %0d",
							results_seen, duty_fine, want_pwm.duty));
					end
					if (average_sum !== want_pwm.average) begin
						report_mismatch($sformatf("result %0d average_sum %0d, expected %0d",
							results_seen, average_sum, want_pwm.average));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				// The predictor always runs so that its state stays in step,
				// even where the table supplies the expected result itself.
				got_pwm = advance_regulator(adc_sample);
				due_pwm.push_back(pinned.on ? pinned.res : got_pwm);
			end
		end
	end

	// Watchdog: the slowest legal run is far below this.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycles, due_pwm.size());
			$display("pwm_hysteresis_step_regulator_top verification failed");
			$finish;
		end
	end

	// Result side. Ready follows segments of random length, each with its own
	// stall density, including stretches that never stall. Once, after a few
	// hundred results and while a sample is on offer, ready is held low for a
	// long stretch while the sender keeps offering, so that the two-entry
	// pipeline fills and in_ready drops.
	initial begin
		int seg;
		int busy;
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER && in_valid) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				seg  = $urandom_range(8, 120);
				busy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 90);
				repeat (seg) begin
					out_ready <= ($urandom_range(0, 99) >= busy);
					@(posedge clk);
				end
			end
		end
	end

	// Waits until every request in flight has produced its result. Both valids
	// are dropped first so that nothing new is offered in the meantime.
	task automatic wait_idle();
		if (results_seen != samples_sent || in_valid) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			do @(posedge clk); while (results_seen != samples_sent);
		end
	endtask

	// Register writes only go out with the pipeline empty. Valid is left high
	// after acceptance so that back-to-back writes need no idle cycle between
	// them; the next sample request or wait drops it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Sample requests go out in bursts of random length, with random gaps in
	// between and now and then a long burst with no gaps at all.
	task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input pin_t pin);
		int gap;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
			gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		adc_sample <= sample;
		pinned     <= pin;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
	endtask

	// A fresh setting for every register. Extremes come up often, and some
	// values carry bits above the register width so that masking is exercised.
	task automatic program_random_regs();
		int r;
		r = $urandom_range(0, 9);
		write_reg(CFG_TARGET_SUM, (r == 0) ? CFG_DATA_W'(0) : (r == 1) ? CFG_DATA_W'(AVG_MAX) :
			(r == 2) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, SUM_MAX)));
		r = $urandom_range(0, 9);
		write_reg(CFG_HYSTERESIS, (r == 0) ? CFG_DATA_W'((1 << HYST_W) - 1) :
			(r == 1) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 12)));
		r = $urandom_range(0, 9);
		write_reg(CFG_STEP_SIZE, (r == 0) ? CFG_DATA_W'(1 << STEP_W) : (r == 1) ?
			CFG_DATA_W'(DUTY_TOP) : (r == 2) ? CFG_DATA_W'($urandom) :
			CFG_DATA_W'($urandom_range(1, 48)));
		r = $urandom_range(0, 7);
		write_reg(CFG_DUTY_UPPER, (r == 0) ? CFG_DATA_W'(DUTY_TOP) : (r == 1) ? CFG_DATA_W'(0) :
			CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
		r = $urandom_range(0, 7);
		write_reg(CFG_DUTY_LOWER, (r == 0) ? CFG_DATA_W'(DUTY_TOP) : (r == 1) ? CFG_DATA_W'(0) :
			CFG_DATA_W'($urandom_range(0, 2048)));
		write_reg(CFG_DITHER_ENABLE, CFG_DATA_W'($urandom));
		if ($urandom_range(0, 3) == 0) begin
			write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO,
				CFG_DATA_W'($urandom));
		end
		settings_used++;
	endtask

	// Most samples sit around the per-sample target so that the sum wanders in
	// and out of the dead band and the duty walks up and down to its limits;
	// the rest are uniform noise or full-scale extremes.
	function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode);
		int centre;
		int spread;
		int v;
		case (mode)
			0: begin
				centre = int'(regs_q.target_sum) / WINDOW;
				if (centre > SAMPLE_MAX) centre = SAMPLE_MAX;
				spread = int'(regs_q.hysteresis) + 4;
				if (spread > SAMPLE_MAX) spread = SAMPLE_MAX;
				v = centre - spread + $urandom_range(0, 2 * spread);
				if (v < 0) v = 0;
				if (v > SAMPLE_MAX) v = SAMPLE_MAX;
			end
			1: v = $urandom_range(0, SAMPLE_MAX);
			default: begin
				case ($urandom_range(0, 2))
					0: v = 0;
					1: v = SAMPLE_MAX;
					default: v = $urandom_range(0, SAMPLE_MAX);
				endcase
			end
		endcase
		return SAMPLE_W'(v);
	endfunction

	initial begin
		int   random_done;
		int   span;
		int   mode;
		int   roll;
		pin_t pin;

		// Every input of the block is driven from time zero.
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		adc_sample <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		pinned     <= '0;

		// Predictor starts from the reset state of the block.
		foreach (ring_q[i]) ring_q[i] = '0;
		sum_q   = '0;
		slot_q  = 0;
		duty_q  = '0;
		phase_q = '0;
		regs_q.target_sum    = TARGET_W'(TARGET_RST);
		regs_q.hysteresis    = HYST_W'(HYST_RST);
		regs_q.step_size     = STEP_W'(STEP_RST);
		regs_q.duty_upper    = DUTY_W'(UPPER_RST);
		regs_q.duty_lower    = DUTY_W'(LOWER_RST);
		regs_q.dither_enable = DITHER_RST[0];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		settings_used = 1;

		foreach (DIRECTED_PLAN[i]) begin
			if (DIRECTED_PLAN[i].kind == ROW_REG) begin
				write_reg(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].value);
			end else begin
				pin.on  = DIRECTED_PLAN[i].pinned;
				pin.res = DIRECTED_PLAN[i].want;
				send_sample(DIRECTED_PLAN[i].value[SAMPLE_W-1:0], pin);
			end
		end

		// Random phases: a new setting, then a run of samples in one style.
		pin = '0;
		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			program_random_regs();
			span = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 300) : $urandom_range(20, 120);
			roll = $urandom_range(0, 19);
			mode = (roll < 12) ? 0 : (roll < 17) ? 1 : 2;
			for (int k = 0; k < span && random_done < RANDOM_ITEMS; k++) begin
				send_sample(pick_sample(mode), pin);
				random_done++;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_pwm.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived", due_pwm.size()));
		end

		$display("Run covered %0d samples and %0d results over %0d register settings (%0d writes).",
			samples_sent, results_seen, settings_used, reg_writes);
		$display("Output held off for %0d cycles once; %0d mismatches counted in %0d cycles.",
			hold_done ? HOLD_CYCLES : 0, mismatches, cycles);
		if (mismatches == 0) begin
			$display("pwm_hysteresis_step_regulator_top verification clean");
		end else begin
			$display("pwm_hysteresis_step_regulator_top verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/psr_pkg.sv
rtl/psr_avg.sv
rtl/psr_duty.sv
rtl/pwm_hysteresis_step_regulator_top.sv
rtl/psr_checker.sv
verif/pwm_hysteresis_step_regulator_top_test.sv
